// ----- design/yuv_matrix_convert_macros.svh -----
// Assertion helpers for the matrix converter
`ifndef YUV_MATRIX_CONVERT_MACROS_SVH
`define YUV_MATRIX_CONVERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define YMC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("yuv_matrix_convert assertion failed");

// checked on every edge, reset included
`define YMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("yuv_matrix_convert assertion failed");

`else

`define YMC_ASSERT(label, clk, rstn, prop)
`define YMC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- design/ymc_pkg.sv -----
package ymc_pkg;

    localparam int IN_DEPTH  = 8;
    localparam int OUT_DEPTH = 8;
    localparam int SUB_WIDE  = 1;
    localparam int SUB_HIGH  = 1;

    localparam int Q_BITS = 14;
    localparam int SHIFT  = Q_BITS + IN_DEPTH - OUT_DEPTH;

    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 16;
    localparam int OFS_W    = 16;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;
    localparam int LANES    = 4;

    // centered chroma and centered luma widths
    localparam int CU_W  = IN_DEPTH + 1;
    localparam int LY_W  = OFS_W + 1;
    localparam int PY_W  = COEF_W + LY_W;
    localparam int PC_W  = COEF_W + CU_W;
    localparam int ACC_W = 40;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [LANES-1:0]         lane_mask_t;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_COEF_Y_FROM_Y = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COEF_Y_FROM_U = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COEF_Y_FROM_V = 3'd2;
    localparam logic [ADDR_W-1:0] REG_COEF_U_FROM_U = 3'd3;
    localparam logic [ADDR_W-1:0] REG_COEF_U_FROM_V = 3'd4;
    localparam logic [ADDR_W-1:0] REG_COEF_V_FROM_U = 3'd5;
    localparam logic [ADDR_W-1:0] REG_COEF_V_FROM_V = 3'd6;
    localparam logic [ADDR_W-1:0] REG_LUMA_OFFSETS  = 3'd7;

    localparam coef_t             COEF_UNITY_RST  = 16'sd16384;
    localparam coef_t             COEF_ZERO_RST   = 16'sd0;
    localparam logic [CFG_W-1:0]  LUMA_OFS_RST    = 32'h0010_0010;

    localparam logic [CU_W-1:0] CHROMA_MID = CU_W'(128 << (IN_DEPTH - 8));
    localparam acc_t HALF        = acc_t'(64'sd1 << (SHIFT - 1));
    localparam acc_t CHROMA_BIAS = acc_t'((64'sd1 << (SHIFT - 1))
                                   + (64'sd128 << (OUT_DEPTH - 8 + SHIFT)));
    localparam acc_t OUT_TOP     = acc_t'((64'sd1 << OUT_DEPTH) - 1);

    localparam lane_mask_t LANE_USED = {
        (SUB_WIDE == 1 && SUB_HIGH == 1),
        (SUB_WIDE == 1 && SUB_HIGH == 1),
        (SUB_WIDE == 1),
        1'b1
    };

    // floor shift, saturate to output depth, keep the field bits
    function automatic sample_t scale_clamp(input acc_t x);
        acc_t s;
        sample_t r;
        s = x >>> SHIFT;
        if (s < 0) begin
            r = '0;
        end else if (s > OUT_TOP) begin
            r = OUT_TOP[SAMPLE_W-1:0];
        end else begin
            r = s[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/yuv_matrix_convert.sv -----
// Channel  Handshake            Payload
// s_       s_valid / s_ready    s_luma_in_00..11, s_chroma_u_in, s_chroma_v_in
// m_       m_valid / m_ready    m_luma_out_00..11, m_chroma_u_out, m_chroma_v_out
// cfg      cfg_wr_en            cfg_addr, cfg_wdata (write only)
//
// One chroma site per clock unless m_ready stalls the result; path: input register, then result register.
// The multiply-add path between the two registers sets the clock.
// Synchronous active-low reset clears both valid stages and loads default coefficients.
// A stalled result holds while the input register still takes a new request if it is free.
`include "yuv_matrix_convert_macros.svh"

module yuv_matrix_convert (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [ymc_pkg::ADDR_W-1:0]         cfg_addr,
    input  logic [ymc_pkg::CFG_W-1:0]          cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  ymc_pkg::sample_t                   s_luma_in_00,
    input  ymc_pkg::sample_t                   s_luma_in_01,
    input  ymc_pkg::sample_t                   s_luma_in_10,
    input  ymc_pkg::sample_t                   s_luma_in_11,
    input  ymc_pkg::sample_t                   s_chroma_u_in,
    input  ymc_pkg::sample_t                   s_chroma_v_in,

    output logic                               m_valid,
    input  logic                               m_ready,
    output ymc_pkg::sample_t                   m_luma_out_00,
    output ymc_pkg::sample_t                   m_luma_out_01,
    output ymc_pkg::sample_t                   m_luma_out_10,
    output ymc_pkg::sample_t                   m_luma_out_11,
    output ymc_pkg::sample_t                   m_chroma_u_out,
    output ymc_pkg::sample_t                   m_chroma_v_out
);

    // configuration
    ymc_pkg::coef_t              coef_yy_reg, coef_yu_reg, coef_yv_reg;
    ymc_pkg::coef_t              coef_uu_reg, coef_uv_reg, coef_vu_reg, coef_vv_reg;
    logic [ymc_pkg::CFG_W-1:0]   luma_ofs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_yy_reg  <= ymc_pkg::COEF_UNITY_RST;
            coef_yu_reg  <= ymc_pkg::COEF_ZERO_RST;
            coef_yv_reg  <= ymc_pkg::COEF_ZERO_RST;
            coef_uu_reg  <= ymc_pkg::COEF_UNITY_RST;
            coef_uv_reg  <= ymc_pkg::COEF_ZERO_RST;
            coef_vu_reg  <= ymc_pkg::COEF_ZERO_RST;
            coef_vv_reg  <= ymc_pkg::COEF_UNITY_RST;
            luma_ofs_reg <= ymc_pkg::LUMA_OFS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ymc_pkg::REG_COEF_Y_FROM_Y: coef_yy_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_Y_FROM_U: coef_yu_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_Y_FROM_V: coef_yv_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_U_FROM_U: coef_uu_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_U_FROM_V: coef_uv_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_V_FROM_U: coef_vu_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_COEF_V_FROM_V: coef_vv_reg  <= cfg_wdata[ymc_pkg::COEF_W-1:0];
                ymc_pkg::REG_LUMA_OFFSETS:  luma_ofs_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: each stage loads when it is empty or the one after it moves
    logic in_valid_reg, out_valid_reg;
    logic out_load;

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input register
    ymc_pkg::sample_t luma_in_reg [ymc_pkg::LANES];
    ymc_pkg::sample_t u_in_reg, v_in_reg;

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            luma_in_reg[0] <= s_luma_in_00;
            luma_in_reg[1] <= s_luma_in_01;
            luma_in_reg[2] <= s_luma_in_10;
            luma_in_reg[3] <= s_luma_in_11;
            u_in_reg       <= s_chroma_u_in;
            v_in_reg       <= s_chroma_v_in;
        end
    end

    // matrix
    logic signed [ymc_pkg::CU_W-1:0] cu, cv;
    logic signed [ymc_pkg::PC_W-1:0] p_yu, p_yv, p_uu, p_uv, p_vu, p_vv;
    logic signed [ymc_pkg::LY_W-1:0] ly [ymc_pkg::LANES];
    logic signed [ymc_pkg::PY_W-1:0] p_yy [ymc_pkg::LANES];
    ymc_pkg::acc_t                   luma_bias, acc_u, acc_v;
    ymc_pkg::acc_t                   acc_y [ymc_pkg::LANES];
    ymc_pkg::sample_t                luma_res [ymc_pkg::LANES];
    ymc_pkg::sample_t                u_res, v_res;

    always_comb begin
        cu = $signed(ymc_pkg::CU_W'(u_in_reg)) - $signed(ymc_pkg::CHROMA_MID);
        cv = $signed(ymc_pkg::CU_W'(v_in_reg)) - $signed(ymc_pkg::CHROMA_MID);

        p_yu = coef_yu_reg * cu;
        p_yv = coef_yv_reg * cv;
        p_uu = coef_uu_reg * cu;
        p_uv = coef_uv_reg * cv;
        p_vu = coef_vu_reg * cu;
        p_vv = coef_vv_reg * cv;

        // output black level lands above the fraction bits
        luma_bias = ymc_pkg::acc_t'(p_yu) + ymc_pkg::acc_t'(p_yv) + ymc_pkg::HALF
                  + (ymc_pkg::acc_t'({1'b0, luma_ofs_reg[ymc_pkg::CFG_W-1:ymc_pkg::OFS_W]})
                     <<< ymc_pkg::SHIFT);
        acc_u = ymc_pkg::acc_t'(p_uu) + ymc_pkg::acc_t'(p_uv) + ymc_pkg::CHROMA_BIAS;
        acc_v = ymc_pkg::acc_t'(p_vu) + ymc_pkg::acc_t'(p_vv) + ymc_pkg::CHROMA_BIAS;
        u_res = ymc_pkg::scale_clamp(acc_u);
        v_res = ymc_pkg::scale_clamp(acc_v);

        for (int i = 0; i < ymc_pkg::LANES; i++) begin
            ly[i]    = $signed(ymc_pkg::LY_W'(luma_in_reg[i]))
                     - $signed({1'b0, luma_ofs_reg[ymc_pkg::OFS_W-1:0]});
            p_yy[i]  = coef_yy_reg * ly[i];
            acc_y[i] = ymc_pkg::acc_t'(p_yy[i]) + luma_bias;
            luma_res[i] = ymc_pkg::LANE_USED[i] ? ymc_pkg::scale_clamp(acc_y[i]) : '0;
        end
    end

    // result register
    ymc_pkg::sample_t luma_out_reg [ymc_pkg::LANES];
    ymc_pkg::sample_t u_out_reg, v_out_reg;

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            for (int i = 0; i < ymc_pkg::LANES; i++) begin
                luma_out_reg[i] <= luma_res[i];
            end
            u_out_reg <= u_res;
            v_out_reg <= v_res;
        end
    end

    assign m_luma_out_00  = luma_out_reg[0];
    assign m_luma_out_01  = luma_out_reg[1];
    assign m_luma_out_10  = luma_out_reg[2];
    assign m_luma_out_11  = luma_out_reg[3];
    assign m_chroma_u_out = u_out_reg;
    assign m_chroma_v_out = v_out_reg;

    `YMC_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid && !in_valid_reg)
    `YMC_ASSERT(a_free_when_empty, aclk, aresetn, !m_valid |-> s_ready)
    `YMC_ASSERT(a_request_captured, aclk, aresetn, (s_valid && s_ready) |=> in_valid_reg)
    `YMC_ASSERT(a_unused_lanes_zero, aclk, aresetn,
        m_valid |-> ((ymc_pkg::LANE_USED[1] || m_luma_out_01 == '0)
            && (ymc_pkg::LANE_USED[3] || (m_luma_out_10 == '0 && m_luma_out_11 == '0))))

endmodule
